// File: design/pfrm_pkg.sv
// Package for the pulse flow rate meter: widths, reset values, register
// indexes, controller commands. No dependencies.
`default_nettype none
package pfrm_pkg;
    localparam int unsigned RingDepth   = 32;
    localparam int unsigned CfgIdxW     = 2;
    localparam int unsigned CfgDataW    = 20;
    localparam logic [CfgIdxW-1:0] REG_WINDOW = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_PPL    = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_GLITCH = 2'd2;
    localparam logic [15:0] WINDOW_RST = 16'd1000;
    localparam logic [19:0] PPL_RST    = 20'd1000;
    localparam logic [7:0]  GLITCH_RST = 8'd0;
    localparam logic [31:0] US_PER_MIN = 32'd60000000;
    localparam logic [9:0]  ML_PER_L   = 10'd1000;

    // controller -> datapath commands
    typedef struct packed {
        logic pulse;      // record a pulse word
        logic start;      // latch request, clear scan state
        logic scan;       // read one ring entry
        logic scan_eval;  // evaluate the registered entry
        logic prep;       // build numerator/denominator
        logic div_step;   // one quotient bit for the flow divider, and for the total divider while it runs
        logic finish;     // load the output register
    } t_cmd;

    typedef struct packed {
        logic scan_last;  // last entry requested this cycle
        logic div_done;
    } t_stat;
endpackage
`default_nettype wire

// File: design/pfrm_ctrl.sv
// Controller state machine for the pulse flow rate meter.
// Depends on pfrm_pkg.
`default_nettype none
module pfrm_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    input  wire              i_mode,
    output logic             o_ready,
    input  wire              i_out_ready,
    output logic             o_out_valid,
    input  wire              i_empty,
    output pfrm_pkg::t_cmd   o_cmd,
    input  pfrm_pkg::t_stat  i_stat
);
    import pfrm_pkg::*;
    localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_EVAL = 3'd2,
                           S_PREP = 3'd3, S_DIV = 3'd4, S_FIN = 3'd5;
    logic [2:0] r_state, n_state;
    logic       r_ovalid, n_ovalid;
    logic       r_scan_d;
    logic       acc;

    assign o_ready     = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign acc         = i_valid && o_ready;

    always_comb begin
        o_cmd    = '0;
        n_state  = r_state;
        n_ovalid = r_ovalid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (acc && !i_mode) begin
                    o_cmd.pulse = 1'b1;
                end else if (acc) begin
                    o_cmd.start = 1'b1;
                    n_state = i_empty ? S_PREP : S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_last) n_state = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.scan_eval = 1'b1;
                n_state = S_PREP;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_done) n_state = S_FIN;
            end
            S_FIN: begin
                // hold until the previous result word has left
                if (!(r_ovalid && !i_out_ready)) begin
                    o_cmd.finish = 1'b1;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        // scan runs one entry behind the read; evaluate previous while reading next
        if (r_state == S_SCAN && !o_cmd.start) o_cmd.scan_eval = r_scan_d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_scan_d <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_scan_d <= (r_state == S_SCAN);
        end
    end
endmodule
`default_nettype wire

// File: design/pfrm_dp.sv
// Datapath for the pulse flow rate meter: timestamp ring memory, window
// scan, two restoring dividers side by side, output register. Depends on pfrm_pkg.
`default_nettype none
module pfrm_dp #(
    parameter int unsigned RING_DEPTH = pfrm_pkg::RingDepth
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire  [31:0]                  i_time_ms,
    input  wire  [15:0]                  i_window,
    input  wire  [19:0]                  i_ppl,
    input  wire  [7:0]                   i_glitch,
    input  pfrm_pkg::t_cmd               i_cmd,
    output pfrm_pkg::t_stat              o_stat,
    output logic                         o_empty,
    output logic [31:0]                  o_flow_ml_per_min,
    output logic [31:0]                  o_total_ml,
    output logic [31:0]                  o_pulse_total
);
    import pfrm_pkg::*;
    localparam int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int unsigned CW = $clog2(RING_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(RING_DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);

    logic [31:0]   r_ring [RING_DEPTH];
    logic [31:0]   r_rd;
    logic [AW-1:0] r_wslot;
    logic [CW-1:0] r_count;
    logic [31:0]   r_pulses;
    logic [31:0]   r_now;
    logic [AW-1:0] r_raddr;
    logic [CW-1:0] r_left;
    logic [CW-1:0] r_n;
    logic [31:0]   r_first, r_last;
    logic [95:0]   r_rem;      // flow remainder
    logic [95:0]   r_den;      // 2*den
    logic [95:0]   r_quo;      // flow quotient, numerator shifted in
    logic [6:0]    r_bit;
    logic [31:0]   r_trem, r_tquo;
    logic          r_fzero, r_tzero;

    assign o_empty = (r_count < CW'(2));
    assign o_stat.scan_last = (r_left == CW'(1));
    // last quotient bit is taken this cycle
    assign o_stat.div_done  = (r_bit == 7'd1);

    // ring memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.pulse) r_ring[r_wslot] <= i_time_ms;
        r_rd <= r_ring[r_raddr];
    end

    logic [31:0] age;
    logic [31:0] span;
    logic        in_win;
    logic [95:0] rem_sh, rem_sub;
    logic [31:0] trem_sh;
    logic [32:0] trem_sub;
    logic [AW-1:0] oldest;
    always_comb begin
        age    = r_now - r_rd;
        in_win = (age <= {16'd0, i_window});
        span   = r_last - r_first;
        rem_sh = {r_rem[94:0], r_quo[95]};
        rem_sub = rem_sh - r_den;
        trem_sh = {r_trem[30:0], r_tquo[31]};
        trem_sub = {1'b0, trem_sh} - {13'd0, i_ppl};
        oldest = r_wslot - AW'(r_count);
        if (RING_DEPTH != (1 << AW) && r_wslot < AW'(r_count))
            oldest = AW'(r_wslot + AW'(RING_DEPTH) - AW'(r_count));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wslot  <= '0;
            r_count  <= '0;
            r_pulses <= '0;
        end else if (i_cmd.pulse) begin
            r_wslot  <= (r_wslot == LAST_SLOT) ? '0 : r_wslot + AW'(1);
            if (r_count != DEPTH_C) r_count <= r_count + CW'(1);
            r_pulses <= r_pulses + 32'd1;
        end
    end

    logic [63:0] num2;
    logic [63:0] den64;
    always_comb begin
        num2  = 64'(r_n - CW'(1)) * 64'(US_PER_MIN) * 64'd2;
        den64 = 64'(span) * 64'(i_ppl);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_now   <= i_time_ms;
            r_raddr <= oldest;
            r_left  <= r_count;
            r_n     <= '0;
        end
        if (i_cmd.scan) begin
            r_raddr <= (r_raddr == LAST_SLOT) ? '0 : r_raddr + AW'(1);
            r_left  <= r_left - CW'(1);
        end
        if (i_cmd.scan_eval && in_win) begin
            if (r_n == '0) r_first <= r_rd;
            r_last <= r_rd;
            r_n    <= r_n + CW'(1);
        end
        if (i_cmd.prep) begin
            r_fzero <= (r_n < CW'(2)) || (i_window == 16'd0) || (span == 32'd0)
                    || (i_ppl == 20'd0)
                    || ((r_n == CW'(2)) && (i_glitch != 8'd0) && (span < 32'(i_glitch)));
            r_tzero <= (i_ppl == 20'd0);
            r_rem   <= '0;
            r_den   <= {31'd0, den64, 1'b0};
            r_quo   <= {32'd0, num2 + den64};   // 2*num + den
            r_trem  <= '0;
            r_tquo  <= r_pulses * 32'(ML_PER_L);
            r_bit   <= 7'd96;
        end
        if (i_cmd.div_step) begin
            r_bit <= r_bit - 7'd1;
            if (rem_sh >= r_den) begin
                r_rem <= rem_sub;
                r_quo <= {r_quo[94:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_quo <= {r_quo[94:0], 1'b0};
            end
            if (r_bit > 7'd64) begin
                if (!trem_sub[32]) begin
                    r_trem <= trem_sub[31:0];
                    r_tquo <= {r_tquo[30:0], 1'b1};
                end else begin
                    r_trem <= trem_sh;
                    r_tquo <= {r_tquo[30:0], 1'b0};
                end
            end
        end
        if (i_cmd.finish) begin
            o_flow_ml_per_min <= r_fzero ? 32'd0
                               : (r_quo[95:32] != 64'd0) ? 32'hFFFF_FFFF : r_quo[31:0];
            o_total_ml    <= r_tzero ? 32'd0 : r_tquo;
            o_pulse_total <= r_pulses;
        end
    end
endmodule
`default_nettype wire

// File: design/pulse_flow_rate_meter_core.sv
// Top level of the pulse flow rate meter: configuration registers,
// controller and datapath. Depends on pfrm_pkg, pfrm_ctrl, pfrm_dp.
`default_nettype none
// A pulse word (mode 0) puts its timestamp into the ring and advances the
// pulse total. A request word (mode 1) walks the stored stamps, one memory
// read per cycle (skipped with fewer than two stored), then runs a 96-step
// restoring divide for the flow alongside the 32-step total-volume divide.
// The result shows and the input reopens at the same edge. The result sits
// in an output register, so new words are taken while it waits; a request
// that finishes before the waiting word leaves holds its last step until it
// does.
module pulse_flow_rate_meter_core #(
    parameter int unsigned RING_DEPTH = pfrm_pkg::RingDepth
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_valid,
    output logic                           o_ready,
    input  wire                            i_mode,
    input  wire  [31:0]                    i_time_ms,
    output logic                           o_valid,
    input  wire                            i_ready,
    output logic [31:0]                    o_flow_ml_per_min,
    output logic [31:0]                    o_total_ml,
    output logic [31:0]                    o_pulse_total,
    input  wire                            i_cfg_we,
    input  wire  [pfrm_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  wire  [pfrm_pkg::CfgDataW-1:0]  i_cfg_data
);
    import pfrm_pkg::*;
    logic [15:0] r_window;
    logic [19:0] r_ppl;
    logic [7:0]  r_glitch;
    t_cmd        cmd;
    t_stat       stat;
    logic        empty;

    // configuration: write only; the user must write it only while idle, the block does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RST;
            r_ppl    <= PPL_RST;
            r_glitch <= GLITCH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WINDOW: r_window <= i_cfg_data[15:0];
                REG_PPL:    r_ppl    <= i_cfg_data;
                REG_GLITCH: r_glitch <= i_cfg_data[7:0];
                default:    ;
            endcase
        end
    end

    pfrm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_mode(i_mode),
        .o_ready(o_ready), .i_out_ready(i_ready), .o_out_valid(o_valid),
        .i_empty(empty), .o_cmd(cmd), .i_stat(stat)
    );

    pfrm_dp #(.RING_DEPTH(RING_DEPTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_time_ms(i_time_ms),
        .i_window(r_window), .i_ppl(r_ppl), .i_glitch(r_glitch),
        .i_cmd(cmd), .o_stat(stat), .o_empty(empty),
        .o_flow_ml_per_min(o_flow_ml_per_min), .o_total_ml(o_total_ml),
        .o_pulse_total(o_pulse_total)
    );
endmodule
`default_nettype wire

// File: design/pfrm_checker.sv
// Port-level checks for pulse_flow_rate_meter_core, with its bind.
// Uses no package and no configuration ports.
`default_nettype none
module pfrm_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_valid,
    input wire        o_ready,
    input wire        i_mode,
    input wire        o_valid,
    input wire        i_ready,
    input wire [31:0] o_flow_ml_per_min,
    input wire [31:0] o_pulse_total
);
    // a stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_flow_ml_per_min) && $stable(o_pulse_total))
        else $error("result changed while stalled");
    // a pulse word gives no result next cycle
    a_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && !i_mode && !(o_valid && !i_ready) |=> !o_valid)
        else $error("pulse produced a result");
    // an accepted request closes the input
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_mode |=> !o_ready)
        else $error("accepted during a request");
endmodule
bind pulse_flow_rate_meter_core pfrm_checker u_chk (.*);
`default_nettype wire

// File: tb/sv/pulse_flow_rate_meter_core_tb.sv
// Testbench for pulse_flow_rate_meter_core: directed and random pulse and
// request words with a built-in flow predictor and in-order result checking.
// Depends on pfrm_pkg and the core RTL.
`default_nettype none
module pulse_flow_rate_meter_core_tb;
    import pfrm_pkg::*;

    localparam int unsigned DEPTH = RingDepth;
    localparam int unsigned IDLE_LIMIT = 20000;
    localparam int unsigned DRAIN_CYCLES = 300;
    localparam bit MODE_PULSE = 1'b0;
    localparam bit MODE_REQ   = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [31:0] time_ms;
    } t_word;

    typedef struct packed {
        logic [31:0] flow;
        logic [31:0] total;
        logic [31:0] pulses;
    } t_meter_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_mode = 1'b0;
    logic [31:0] i_time_ms = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_flow_ml_per_min;
    logic [31:0] o_total_ml;
    logic [31:0] o_pulse_total;
    logic        i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_idx = '0;
    logic [CfgDataW-1:0] i_cfg_data = '0;

    always #6 i_clk = ~i_clk;

    pulse_flow_rate_meter_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_mode(i_mode), .i_time_ms(i_time_ms),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_flow_ml_per_min(o_flow_ml_per_min), .o_total_ml(o_total_ml),
        .o_pulse_total(o_pulse_total),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // predictor state: shadow registers and ring
    logic [15:0] win_ms;
    logic [19:0] ppl;
    logic [7:0]  glitch_ms;
    logic [31:0] stamps [DEPTH];
    int unsigned wr_slot;
    int unsigned n_stored;
    logic [31:0] pulse_cnt;

    t_word      word_q[$];
    t_meter_out meter_q[$];

    int unsigned n_sent;
    int unsigned n_bad;
    int unsigned idle_cycles;
    bit          hold_send;     // sender pause until drained
    int unsigned stall_long;    // long receiver hold-off, in cycles
    int unsigned burst_left;
    int unsigned gap_left;
    int unsigned stall_phase;

    // Work out the rounded flow for a request at tick now.
    function automatic logic [31:0] flow_at(logic [31:0] now);
        int unsigned hits;
        int unsigned oldest;
        logic [31:0] first_t, last_t, t, span;
        logic [127:0] num, den, q;
        hits = 0;
        first_t = '0;
        last_t = '0;
        if (n_stored < 2 || win_ms == 0) return '0;
        oldest = (wr_slot + DEPTH - n_stored) % DEPTH;
        for (int i = 0; i < n_stored; i++) begin
            t = stamps[(oldest + i) % DEPTH];
            if (32'(now - t) <= {16'd0, win_ms}) begin
                if (hits == 0) first_t = t;
                last_t = t;
                hits++;
            end
        end
        if (hits < 2) return '0;
        span = last_t - first_t;
        if (span == 0) return '0;
        if (hits == 2 && glitch_ms != 0 && span < {24'd0, glitch_ms}) return '0;
        if (ppl == 0) return '0;
        num = 128'(hits - 1) * 128'd60000000;
        den = 128'(span) * 128'(ppl);
        q = (2 * num + den) / (2 * den);
        if (q > 128'hFFFF_FFFF) return 32'hFFFF_FFFF;
        return q[31:0];
    endfunction

    // Advance the shadow state for one accepted word; queue any result.
    task automatic absorb_word(t_word w);
        t_meter_out r;
        logic [31:0] vol;
        if (w.mode == MODE_PULSE) begin
            stamps[wr_slot] = w.time_ms;
            wr_slot = (wr_slot + 1) % DEPTH;
            if (n_stored < DEPTH) n_stored++;
            pulse_cnt++;
        end else begin
            vol = pulse_cnt * 32'd1000;
            r.flow = flow_at(w.time_ms);
            r.total = (ppl == 0) ? 32'd0 : vol / {12'd0, ppl};
            r.pulses = pulse_cnt;
            meter_q.push_back(r);
        end
    endtask

    // Driver: bursts of words with random gaps; valid held until accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else begin
            if (i_valid && o_ready) begin
                absorb_word('{mode: i_mode, time_ms: i_time_ms});
                n_sent++;
            end
            if (!i_valid || o_ready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    i_valid <= 1'b0;
                end else if (word_q.size() != 0 && !hold_send) begin
                    t_word w;
                    w = word_q.pop_front();
                    i_mode <= w.mode;
                    i_time_ms <= w.time_ms;
                    i_valid <= 1'b1;
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 20);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: receiver stall pattern, long hold-off, and result checking.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            stall_phase <= 0;
        end else begin
            if (o_valid && i_ready) begin
                if (meter_q.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("unexpected result flow=%0d total=%0d pulses=%0d",
                                 o_flow_ml_per_min, o_total_ml, o_pulse_total);
                end else begin
                    t_meter_out e;
                    e = meter_q.pop_front();
                    if (e.flow !== o_flow_ml_per_min || e.total !== o_total_ml
                        || e.pulses !== o_pulse_total) begin
                        n_bad++;
                        if (n_bad <= 10)
                            $display("mismatch flow exp=%0d got=%0d total exp=%0d got=%0d pulses exp=%0d got=%0d",
                                     e.flow, o_flow_ml_per_min, e.total, o_total_ml,
                                     e.pulses, o_pulse_total);
                    end
                end
            end
            stall_phase <= stall_phase + 1;
            if (stall_long != 0) begin
                stall_long <= stall_long - 1;
                i_ready <= 1'b0;
            end else if (stall_phase[9:8] == 2'd3) begin
                i_ready <= 1'b1;       // stretch with no stalls
            end else begin
                i_ready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    // Watchdog: count cycles with no handshake on either side.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n || hold_send)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic push_word(logic mode, logic [31:0] t);
        word_q.push_back('{mode: mode, time_ms: t});
    endtask

    // Wait until everything queued is accepted and every result has come.
    task automatic drain();
        while (word_q.size() != 0 || i_valid || meter_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_WINDOW: win_ms = val[15:0];
            REG_PPL:    ppl = val;
            REG_GLITCH: glitch_ms = val[7:0];
            default: ;
        endcase
    endtask

    // One random phase: pulse trains with requests mixed in, some noise.
    task automatic random_phase(int unsigned n_words, logic [31:0] base);
        logic [31:0] now;
        int unsigned step_max;
        now = base;
        step_max = $urandom_range(1, 4) == 1 ? 2 : $urandom_range(5, 200);
        for (int i = 0; i < n_words; i++) begin
            if ($urandom_range(0, 9) == 0)
                now = $urandom;                    // noise: random jump
            else
                now = now + $urandom_range(0, step_max);
            push_word(($urandom_range(0, 3) == 0) ? MODE_REQ : MODE_PULSE, now);
        end
    endtask

    initial begin
        logic [31:0] t0;
        win_ms = WINDOW_RST;
        ppl = PPL_RST;
        glitch_ms = GLITCH_RST;
        wr_slot = 0;
        n_stored = 0;
        pulse_cnt = '0;
        n_sent = 0;
        n_bad = 0;
        idle_cycles = 0;
        hold_send = 0;
        stall_long = 0;
        for (int i = 0; i < DEPTH; i++) stamps[i] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: too few pulses, zero span, wrap, glitch, extremes.
        push_word(MODE_REQ, 32'hFFFF_FFFF);             // empty ring
        push_word(MODE_PULSE, 32'hFFFF_FFF0);
        push_word(MODE_REQ, 32'hFFFF_FFF5);             // one pulse
        push_word(MODE_PULSE, 32'hFFFF_FFF0);
        push_word(MODE_REQ, 32'hFFFF_FFF8);             // zero span
        push_word(MODE_PULSE, 32'h0000_0005);           // across the wrap
        push_word(MODE_REQ, 32'h0000_0010);
        push_word(MODE_REQ, 32'h0000_5000);             // all aged out
        push_word(MODE_PULSE, 32'h0000_5001);
        push_word(MODE_PULSE, 32'h0000_5002);           // span 1: huge flow
        push_word(MODE_REQ, 32'h0000_5002);
        drain();
        write_reg(REG_GLITCH, 20'hFF);
        write_reg(REG_PPL, 20'd1);
        push_word(MODE_REQ, 32'h0000_5002);             // glitch with two in the window
        push_word(MODE_PULSE, 32'h0001_0000);
        push_word(MODE_PULSE, 32'h0001_0010);
        push_word(MODE_REQ, 32'h0001_0010);             // exactly two: glitch
        drain();
        write_reg(REG_WINDOW, 20'd0);
        write_reg(REG_GLITCH, 20'd0);
        push_word(MODE_REQ, 32'h0001_0010);             // zero window
        drain();
        write_reg(REG_WINDOW, 20'hFFFF);
        write_reg(REG_PPL, 20'd0);
        push_word(MODE_REQ, 32'h0001_0010);             // zero calibration
        drain();
        write_reg(REG_PPL, 20'hFFFFF);
        push_word(MODE_REQ, 32'h0001_0010);
        push_word(MODE_PULSE, 32'hAAAA_5555);
        push_word(MODE_PULSE, 32'h5555_AAAA);
        push_word(MODE_REQ, 32'h5555_AAAA);
        drain();

        // Random phases under varied settings, extremes included.
        for (int ph = 0; ph < 10; ph++) begin
            case (ph % 5)
                0: begin
                    write_reg(REG_WINDOW, CfgDataW'($urandom_range(1, 400)));
                    write_reg(REG_PPL, CfgDataW'($urandom_range(1, 5000)));
                    write_reg(REG_GLITCH, CfgDataW'($urandom_range(0, 255)));
                end
                1: begin
                    write_reg(REG_WINDOW, 20'hFFFF);
                    write_reg(REG_PPL, 20'hFFFFF);
                    write_reg(REG_GLITCH, 20'hFF);
                end
                2: begin
                    write_reg(REG_WINDOW, CfgDataW'($urandom_range(0, 65535)));
                    write_reg(REG_PPL, CfgDataW'($urandom_range(0, 1048575)));
                    write_reg(REG_GLITCH, 20'd0);
                end
                3: begin
                    write_reg(REG_WINDOW, 20'd1);
                    write_reg(REG_PPL, 20'd1);
                    write_reg(REG_GLITCH, 20'd1);
                end
                default: begin
                    write_reg(REG_WINDOW, CfgDataW'($urandom_range(500, 3000)));
                    write_reg(REG_PPL, CfgDataW'($urandom_range(0, 3) == 0 ? 0
                                                 : $urandom_range(1, 1000)));
                    write_reg(REG_GLITCH, CfgDataW'($urandom_range(0, 40)));
                end
            endcase
            t0 = $urandom;
            random_phase(110, t0);
            if (ph == 3) begin
                // hold the receiver off long enough to back up the input
                stall_long = 3000;
            end
            if (ph == 6) begin
                // pause the sender until every result is in
                while (word_q.size() > 60) @(posedge i_clk);
                hold_send = 1;
                while (i_valid || meter_q.size() != 0) @(posedge i_clk);
                repeat (DRAIN_CYCLES) @(posedge i_clk);
                hold_send = 0;
            end
            drain();
        end

        if (n_bad == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
